// File: rtl/srs_pkg.sv
// Package for the sweep range segmenter: widths, limits, payload and control structs.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package srs_pkg;

	// Frequency word and run limit
	localparam int FREQ_BITS    = 48;
	localparam int MAX_SEGMENTS = 64;
	localparam int CNT_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int DIV_CNT_W    = $clog2(FREQ_BITS);

	// Configuration port geometry: four 48-bit registers at 8-byte spacing
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 5;

	typedef logic [FREQ_BITS-1:0] freq_t;

	localparam freq_t FREQ_MAX = '1;

	// Register indexes
	typedef enum logic [1:0] {
		REG_RX_MIN   = 2'd0,
		REG_RX_MAX   = 2'd1,
		REG_SPAN     = 2'd2,
		REG_MIN_STEP = 2'd3
	} reg_idx_t;

	// Register reset values
	localparam freq_t RX_MIN_RST   = '0;
	localparam freq_t RX_MAX_RST   = FREQ_MAX;
	localparam freq_t SPAN_RST     = freq_t'(20000000);
	localparam freq_t MIN_STEP_RST = freq_t'(1000);

	// Request transaction
	typedef struct packed {
		freq_t       range_lower_hz;
		freq_t       range_upper_hz;
		freq_t       req_res_hz;
		logic [23:0] dwell_time_us;
		logic [1:0]  request_priority;
		logic [2:0]  request_intent;
	} req_t;

	// Result transaction
	typedef struct packed {
		freq_t       seg_lower_hz;
		freq_t       seg_upper_hz;
		freq_t       seg_center_hz;
		freq_t       seg_width_hz;
		freq_t       seg_bin_hz;
		logic [23:0] seg_dwell_us;
		logic [1:0]  seg_priority;
		logic [2:0]  seg_intent;
		logic        last_segment;
		logic        truncated;
	} seg_t;

	// Clipped job handed from the front end to the segment engine
	typedef struct packed {
		freq_t       lo;
		freq_t       hi;
		freq_t       bin;
		logic [23:0] dwell;
		logic [1:0]  prio;
		logic [2:0]  intent;
	} job_t;

	// Configuration register group
	typedef struct packed {
		freq_t rx_min;
		freq_t rx_max;
		freq_t span;
		freq_t min_step;
	} cfg_t;

	// Queue status of the job queue, seen by the front end and the segment engine
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// File: rtl/srs_front.sv
// Front end: takes request transactions, clips them to the tuning limits, drops
// empty ones and pushes the rest as jobs. Depends on srs_pkg.
`default_nettype none

module srs_front
	import srs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	output logic         full,
	input  wire req_t    req,
	input  wire cfg_t    cfg,
	output logic         job_push,
	output job_t         job,
	input  wire q_stat_t job_q_stat
);

	logic  valid_s1;
	req_t  req_s1;
	freq_t lo_c;
	freq_t hi_c;
	logic  drop;
	logic  advance;

	// Clip and classify the captured request
	always_comb begin
		lo_c = (req_s1.range_lower_hz < cfg.rx_min) ? cfg.rx_min : req_s1.range_lower_hz;
		hi_c = (req_s1.range_upper_hz > cfg.rx_max) ? cfg.rx_max : req_s1.range_upper_hz;
		drop = (req_s1.range_upper_hz <= req_s1.range_lower_hz) || (hi_c <= lo_c);
	end

	always_comb begin
		job.lo     = lo_c;
		job.hi     = hi_c;
		job.bin    = (req_s1.req_res_hz > cfg.min_step) ? req_s1.req_res_hz
		                                                : cfg.min_step;
		job.dwell  = req_s1.dwell_time_us;
		job.prio   = req_s1.request_priority;
		job.intent = req_s1.request_intent;
	end

	assign advance  = !valid_s1 || drop || !job_q_stat.full;
	assign job_push = valid_s1 && !drop && !job_q_stat.full;
	assign full     = !advance;

	// Capture stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push) begin
			req_s1 <= req;
		end
	end

endmodule

`default_nettype wire

// File: rtl/srs_job_q.sv
// Two-entry job queue between the front end and the segment engine.
// Depends on srs_pkg.
`default_nettype none

module srs_job_q
	import srs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t wr_job,
	input  wire logic pop,
	output job_t      rd_job,
	output q_stat_t   stat
);

	job_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign stat.full  = (count_q == 2'd2);
	assign stat.empty = (count_q == 2'd0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_job     = entry_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

`default_nettype wire

// File: rtl/srs_seg_engine.sv
// Segment engine: walks a job's range segment by segment, rounding edges up to
// the bin width with a bit-serial remainder unit. Depends on srs_pkg.
`default_nettype none

module srs_seg_engine
	import srs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire freq_t   span,
	input  wire job_t    job,
	input  wire q_stat_t job_q_stat,
	output logic         job_pop,
	output logic         empty,
	input  wire logic    pop,
	output seg_t         seg
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_ADD   = 7'b0000010,
		ST_DIV   = 7'b0000100,
		ST_GAP   = 7'b0001000,
		ST_ROUND = 7'b0010000,
		ST_WID   = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t               state_q;
	job_t                 job_q;
	freq_t                cursor_q;
	freq_t                up_q;
	freq_t                width_q;
	freq_t                rem_q;
	freq_t                dvd_q;
	freq_t                gap_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 last_q;
	logic                 trunc_q;
	logic                 out_valid_q;
	seg_t                 out_q;

	logic [FREQ_BITS:0]   add_sum;
	freq_t                add_sat;
	logic [FREQ_BITS:0]   rnd_sum;
	freq_t                rnd_sat;
	logic [FREQ_BITS:0]   trial;
	logic                 trial_ge;
	logic                 out_load;

	// Span add and round-up add, both saturating
	always_comb begin
		add_sum = {1'b0, cursor_q} + {1'b0, span};
		add_sat = add_sum[FREQ_BITS] ? FREQ_MAX : add_sum[FREQ_BITS-1:0];
		rnd_sum = {1'b0, up_q} + {1'b0, gap_q};
		rnd_sat = rnd_sum[FREQ_BITS] ? FREQ_MAX : rnd_sum[FREQ_BITS-1:0];
	end

	// One restoring step of the remainder
	always_comb begin
		trial    = {rem_q, dvd_q[FREQ_BITS-1]};
		trial_ge = (trial >= {1'b0, job_q.bin});
	end

	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || pop);
	assign job_pop  = (state_q == ST_IDLE) && !job_q_stat.empty;
	assign empty    = !out_valid_q;
	assign seg      = out_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!job_q_stat.empty) state_q <= ST_ADD;
				end
				ST_ADD: begin
					if ((add_sat < job_q.hi) && (job_q.bin != '0)) state_q <= ST_DIV;
					else state_q <= ST_WID;
				end
				ST_DIV: begin
					if (div_cnt_q == DIV_CNT_W'(FREQ_BITS - 1)) state_q <= ST_GAP;
				end
				ST_GAP: begin
					state_q <= (rem_q == '0) ? ST_WID : ST_ROUND;
				end
				ST_ROUND: begin
					state_q <= ST_WID;
				end
				ST_WID: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load) state_q <= last_q ? ST_IDLE : ST_ADD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				job_q    <= job;
				cursor_q <= job.lo;
				cnt_q    <= '0;
			end
			ST_ADD: begin
				up_q      <= (add_sat > job_q.hi) ? job_q.hi : add_sat;
				dvd_q     <= (add_sat > job_q.hi) ? job_q.hi : add_sat;
				rem_q     <= '0;
				div_cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q     <= trial_ge ? freq_t'(trial - {1'b0, job_q.bin})
				                      : trial[FREQ_BITS-1:0];
				dvd_q     <= {dvd_q[FREQ_BITS-2:0], 1'b0};
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			ST_GAP: begin
				gap_q <= job_q.bin - rem_q;
			end
			ST_ROUND: begin
				up_q <= (rnd_sat > job_q.hi) ? job_q.hi : rnd_sat;
			end
			ST_WID: begin
				width_q <= up_q - cursor_q;
				last_q  <= (up_q <= cursor_q) || (up_q >= job_q.hi)
				           || (cnt_q == CNT_W'(MAX_SEGMENTS - 1));
				trunc_q <= !((up_q <= cursor_q) || (up_q >= job_q.hi))
				           && (cnt_q == CNT_W'(MAX_SEGMENTS - 1));
			end
			ST_EMIT: begin
				if (out_load && !last_q) begin
					cursor_q <= up_q;
					cnt_q    <= cnt_q + 1'b1;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.seg_lower_hz  <= cursor_q;
			out_q.seg_upper_hz  <= up_q;
			out_q.seg_center_hz <= cursor_q + (width_q >> 1);
			out_q.seg_width_hz  <= width_q;
			out_q.seg_bin_hz    <= job_q.bin;
			out_q.seg_dwell_us  <= job_q.dwell;
			out_q.seg_priority  <= job_q.prio;
			out_q.seg_intent    <= job_q.intent;
			out_q.last_segment  <= last_q;
			out_q.truncated     <= trunc_q;
		end
	end

endmodule

`default_nettype wire

// File: rtl/sweep_range_segmenter_top.sv
// Sweep range segmenter: top level with the configuration registers.
// Depends on srs_pkg, srs_front, srs_job_q and srs_seg_engine.
//
// Use: write request transactions with push while full is low. Each request is
// clipped to [rx_min, rx_max] and cut into segments of the configured span, their
// upper edges rounded up to whole bins; results come out of a queue-like port:
// while empty is low the oldest segment is on seg, and pop takes it. Empty or
// fully clipped requests give no results. At most 64 segments per request; the
// last one carries last_segment, and truncated when the limit cut the range short.
// A request passes the capture stage and the job queue before the engine takes
// it. Each segment runs the add, width and emit steps; when its edge falls short
// of the range end and the bin width is not zero, the bit-serial remainder unit
// (one bit per cycle over 48 bits) and a gap step come between, and the unit sets
// the rate; a round-up step follows a nonzero remainder. Requests are handled one
// at a time; three more can wait, one in the capture stage, two in the job queue.
// A stalled receiver holds the output register; the engine waits and the
// front end keeps taking requests until its queue is full.
// Reset (arst_n low) empties everything and loads the register reset values.
// Registers sit at byte addresses 0, 8, 16, 24 (rx_min, rx_max, span, min_step).
`default_nettype none

module sweep_range_segmenter_top
	import srs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire req_t                  req,
	output logic                       empty,
	input  wire logic                  pop,
	output seg_t                       seg,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0]      prdata,
	output logic                       pready
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;
	logic     job_push;
	job_t     job_in;
	job_t     job_out;
	logic     job_pop;
	q_stat_t  job_q_stat;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rx_min   <= RX_MIN_RST;
			cfg_q.rx_max   <= RX_MAX_RST;
			cfg_q.span     <= SPAN_RST;
			cfg_q.min_step <= MIN_STEP_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_RX_MIN:   cfg_q.rx_min   <= pwdata[FREQ_BITS-1:0];
				REG_RX_MAX:   cfg_q.rx_max   <= pwdata[FREQ_BITS-1:0];
				REG_SPAN:     cfg_q.span     <= pwdata[FREQ_BITS-1:0];
				REG_MIN_STEP: cfg_q.min_step <= pwdata[FREQ_BITS-1:0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (reg_idx)
			REG_RX_MIN:   prdata = CFG_DATA_W'(cfg_q.rx_min);
			REG_RX_MAX:   prdata = CFG_DATA_W'(cfg_q.rx_max);
			REG_SPAN:     prdata = CFG_DATA_W'(cfg_q.span);
			REG_MIN_STEP: prdata = CFG_DATA_W'(cfg_q.min_step);
			default:      prdata = '0;
		endcase
	end

	srs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req        (req),
		.cfg        (cfg_q),
		.job_push   (job_push),
		.job        (job_in),
		.job_q_stat (job_q_stat)
	);

	srs_job_q u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wr_job (job_in),
		.pop    (job_pop),
		.rd_job (job_out),
		.stat   (job_q_stat)
	);

	srs_seg_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.span       (cfg_q.span),
		.job        (job_out),
		.job_q_stat (job_q_stat),
		.job_pop    (job_pop),
		.empty      (empty),
		.pop        (pop),
		.seg        (seg)
	);

endmodule

`default_nettype wire

// File: rtl/srs_checker.sv
// Port-level checks for the sweep range segmenter, bound to the top level.
// Depends on srs_pkg and sweep_range_segmenter_top.
`default_nettype none

module srs_checker
	import srs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic empty,
	input wire logic pop,
	input wire seg_t seg,
	input wire logic pready
);

	// A waiting result is not withdrawn or altered before it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(seg))
		else $error("result changed while waiting");

	// Truncation only on the final segment
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && seg.truncated |-> seg.last_segment)
		else $error("truncated without last_segment");

	// Segment edges are ordered and width matches them
	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (seg.seg_upper_hz >= seg.seg_lower_hz)
		&& (seg.seg_width_hz == seg.seg_upper_hz - seg.seg_lower_hz))
		else $error("segment edges or width inconsistent");

	// Center lies inside the segment
	a_center: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (seg.seg_center_hz >= seg.seg_lower_hz)
		&& (seg.seg_center_hz <= seg.seg_upper_hz))
		else $error("segment center outside edges");

	// A non-advancing segment must end the run
	a_stall_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (seg.seg_width_hz == '0) |-> seg.last_segment && pready)
		else $error("zero-width segment not marked last");

endmodule

bind sweep_range_segmenter_top srs_checker u_srs_checker (.*);

`default_nettype wire
